// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assertion checked only while out of reset
`define RCUF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion checked at every edge, reset included
`define RCUF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/rcuf_pkg.sv =====
`default_nettype none
package rcuf_pkg;
  localparam int unsigned MAX_ENTITIES_DEF = 4095;
  localparam logic [11:0] ENT_COUNT_RESET = 12'd4095;

  typedef struct packed {
    logic        mode;
    logic        relation;
    logic [11:0] first_id;
    logic [11:0] second_id;
  } in_t;

  typedef struct packed {
    logic        statement_false;
    logic [15:0] false_total;
  } out_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_NEXT,
    ST_LINK
  } state_t;
endpackage
`default_nettype wire

// ===== sv/relation_consistency_union_find.sv =====
// invalid statement: result strobe in the cycle after acceptance; otherwise parent links are
// walked and the result follows the first three root walks on a contradiction, else the merge
// throughput: one item at a time; busy is high from acceptance to the result strobe, never for
// an invalid statement; each root walk reads one parent entry per cycle over one read port
// clear item: one sweep over all 3 * (MAX_ENTITIES + 1) parent entries, then the result strobe
// reset (rst_n low, synchronous): same sweep with no result; count zero, entity_count 4095
`default_nettype none
module relation_consistency_union_find #(
  parameter int unsigned MAX_ENTITIES = rcuf_pkg::MAX_ENTITIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire rcuf_pkg::in_t in_item,
  output logic               out_valid,
  output rcuf_pkg::out_t     out_item,
  input  wire logic          cfg_we,
  input  wire logic [11:0]   cfg_data
);
  import rcuf_pkg::*;

  localparam int unsigned Depth = (MAX_ENTITIES + 1) * 3;
  localparam int unsigned NodeW = $clog2(Depth);

  state_t           state_r, state_nxt;
  logic [3:0]       step_r;
  logic [NodeW-1:0] cur_r, ra_r, rb_r, rc_r, sweep_r;
  logic             report_r;
  in_t              item_r;
  logic [15:0]      cnt_r;
  logic [11:0]      ent_r;
  logic             ov_r, ov_nxt;
  out_t             out_r;

  logic [NodeW-1:0] rd_addr, rdata, node_sel;
  logic             we;
  logic [NodeW-1:0] waddr, wdata;
  logic             stmt_false, ids_bad, sweep_end, at_root;
  logic [11:0]      sel_id;
  logic [1:0]       sel_layer;

  function automatic logic id_ok(logic [11:0] id, logic [11:0] ent);
    id_ok = (id != 12'd0) && (id <= ent) && (17'(id) <= 17'(MAX_ENTITIES));
  endfunction

  assign ids_bad = (in_item.first_id == in_item.second_id) ||
                   !id_ok(in_item.first_id, ent_r) || !id_ok(in_item.second_id, ent_r);
  assign stmt_false = (ra_r == rb_r) || (ra_r == rc_r);
  assign sweep_end  = (sweep_r == NodeW'(Depth - 1));
  assign at_root    = (rdata == cur_r);

  assign ov_nxt = ((state_r == ST_SWEEP) && sweep_end && report_r) ||
                  ((state_r == ST_IDLE) && start && !in_item.mode && ids_bad) ||
                  ((state_r == ST_NEXT) && (step_r == 4'd2) && stmt_false) ||
                  ((state_r == ST_LINK) && (step_r == 4'd8));

  always_comb begin
    sel_id    = item_r.second_id;
    sel_layer = 2'd0;
    unique case (step_r)
      4'd0: begin sel_id = item_r.first_id; sel_layer = 2'd0; end
      4'd1: sel_layer = item_r.relation ? 2'd0 : 2'd1;
      4'd2: sel_layer = 2'd2;
      4'd3: begin sel_id = item_r.first_id; sel_layer = 2'd0; end
      4'd4: sel_layer = item_r.relation ? 2'd1 : 2'd0;
      4'd5: begin sel_id = item_r.first_id; sel_layer = 2'd1; end
      4'd6: sel_layer = item_r.relation ? 2'd2 : 2'd1;
      4'd7: begin sel_id = item_r.first_id; sel_layer = 2'd2; end
      default: sel_layer = item_r.relation ? 2'd0 : 2'd2;
    endcase
    node_sel = NodeW'({sel_id, 1'b0}) + NodeW'(sel_id) + NodeW'(sel_layer);
  end

  rcuf_ram #(.WIDTH(NodeW), .DEPTH(Depth)) u_parent (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rd_addr), .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: if (sweep_end) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (in_item.mode) state_nxt = ST_SWEEP;
          else if (!ids_bad) state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_WALK;
      ST_WALK: if (at_root) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (step_r == 4'd2) state_nxt = stmt_false ? ST_IDLE : ST_LOAD;
        else if (step_r == 4'd4 || step_r == 4'd6 || step_r == 4'd8) state_nxt = ST_LINK;
        else state_nxt = ST_LOAD;
      end
      default: state_nxt = (step_r == 4'd8) ? ST_IDLE : ST_LOAD;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = rb_r;
    wdata   = ra_r;
    rd_addr = node_sel;
    unique case (state_r)
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_r;
        wdata = sweep_r;
      end
      ST_WALK: rd_addr = rdata;
      ST_LINK: we = (ra_r != rb_r);
      default: rd_addr = node_sel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SWEEP;
      sweep_r  <= '0;
      report_r <= 1'b0;
      cnt_r    <= '0;
      ent_r    <= ENT_COUNT_RESET;
      ov_r     <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        ent_r <= cfg_data;
      end
      unique case (state_r)
        ST_SWEEP: begin
          sweep_r <= sweep_end ? '0 : sweep_r + 1'b1;
          if (sweep_end) begin
            report_r <= 1'b0;
            if (report_r) begin
              out_r <= '0;
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            item_r <= in_item;
            step_r <= '0;
            if (in_item.mode) begin
              report_r <= 1'b1;
              cnt_r    <= '0;
            end else if (ids_bad) begin
              out_r.statement_false <= 1'b1;
              out_r.false_total     <= (cnt_r != 16'hFFFF) ? cnt_r + 1'b1 : cnt_r;
              if (cnt_r != 16'hFFFF) cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_LOAD: cur_r <= rd_addr;
        ST_WALK: begin
          cur_r <= rd_addr;
          if (at_root) begin
            if (step_r == 4'd2) rc_r <= cur_r;
            else if (step_r == 4'd0 || step_r == 4'd3 || step_r == 4'd5 || step_r == 4'd7)
              ra_r <= cur_r;
            else rb_r <= cur_r;
          end
        end
        ST_NEXT: begin
          if (step_r == 4'd2 && stmt_false) begin
            out_r.statement_false <= 1'b1;
            out_r.false_total     <= (cnt_r != 16'hFFFF) ? cnt_r + 1'b1 : cnt_r;
            if (cnt_r != 16'hFFFF) cnt_r <= cnt_r + 1'b1;
          end else if (!(step_r == 4'd4 || step_r == 4'd6 || step_r == 4'd8)) begin
            step_r <= step_r + 1'b1;
          end
        end
        default: begin
          if (step_r == 4'd8) begin
            out_r.statement_false <= 1'b0;
            out_r.false_total     <= cnt_r;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

// ===== sv/rcuf_ram.sv =====
`default_nettype none
module rcuf_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 12288
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/rcuf_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module rcuf_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire rcuf_pkg::in_t  in_item,
  input wire logic           out_valid,
  input wire rcuf_pkg::out_t out_item
);
  import rcuf_pkg::*;

  logic zero_total;

  assign zero_total = out_valid && (out_item.false_total == 16'd0);

  // sweep after reset
  `RCUF_ASSERT_ALWAYS(a_rst_busy, !rst_n |=> busy, "not busy after reset")
  // a result beat follows an accepted item or busy work
  `RCUF_ASSERT(a_out_cause, out_valid |-> $past(busy || start), "result without cause")
  // result beat ends the item
  `RCUF_ASSERT(a_out_idle, out_valid |-> !busy, "busy during result beat")
  // a clear starts the sweep
  `RCUF_ASSERT(a_clear_sweep, (start && !busy && in_item.mode) |=> busy, "clear did not sweep")
  // a false beat always counts itself
  `RCUF_ASSERT(a_zero_true, zero_total |-> !out_item.statement_false, "false at zero total")
endmodule

bind relation_consistency_union_find rcuf_chk u_rcuf_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire

// ===== sim/rcuf_tb_pkg.sv =====
package rcuf_tb_pkg;
  localparam logic MODE_STATEMENT = 1'b0;
  localparam logic MODE_CLEAR     = 1'b1;
  localparam logic REL_SAME_KIND  = 1'b0;
  localparam logic REL_EATS       = 1'b1;
endpackage

// ===== sim/relation_verdict_checker.sv =====
module relation_verdict_checker
  import rcuf_pkg::*;
  import rcuf_tb_pkg::*;
#(
  parameter int unsigned MAX_ENTITIES = MAX_ENTITIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_item,
  input  logic        out_valid,
  input  out_t        out_item,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES = (MAX_ENTITIES + 1) * 3;

  int unsigned parent_link[NODES];
  logic [15:0] false_tally;
  logic [11:0] id_limit;
  out_t        expected_verdicts[$];

  initial fail_count = 0;
  initial verdicts_pending = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void wipe_forest();
    for (int i = 0; i < NODES; i++) parent_link[i] = i;
  endfunction

  function automatic int unsigned root_of(input int unsigned node);
    int unsigned r;
    int unsigned nxt;
    r = node;
    while (parent_link[r] != r) r = parent_link[r];
    while (node != r) begin
      nxt = parent_link[node];
      parent_link[node] = r;
      node = nxt;
    end
    return r;
  endfunction

  function automatic bit same_set(input int unsigned a, input int unsigned b);
    return root_of(a) == root_of(b);
  endfunction

  function automatic void link_nodes(input int unsigned a, input int unsigned b);
    int unsigned ra;
    int unsigned rb;
    ra = root_of(a);
    rb = root_of(b);
    if (ra != rb) parent_link[rb] = ra;
  endfunction

  function automatic out_t judge_statement(input in_t b);
    out_t        v;
    int unsigned x;
    int unsigned y;
    int unsigned lim;
    bit          bad;
    x = b.first_id;
    y = b.second_id;
    lim = (id_limit > MAX_ENTITIES) ? MAX_ENTITIES : id_limit;
    if (b.mode == MODE_CLEAR) begin
      wipe_forest();
      false_tally = '0;
      v.statement_false = 1'b0;
      v.false_total = '0;
      return v;
    end
    if (x == y || x == 0 || y == 0 || x > lim || y > lim) begin
      bad = 1'b1;
    end else if (b.relation == REL_SAME_KIND) begin
      bad = same_set(x * 3, y * 3 + 1) || same_set(x * 3, y * 3 + 2);
      if (!bad) begin
        link_nodes(x * 3, y * 3);
        link_nodes(x * 3 + 1, y * 3 + 1);
        link_nodes(x * 3 + 2, y * 3 + 2);
      end
    end else begin
      bad = same_set(x * 3, y * 3) || same_set(x * 3, y * 3 + 2);
      if (!bad) begin
        link_nodes(x * 3, y * 3 + 1);
        link_nodes(x * 3 + 1, y * 3 + 2);
        link_nodes(x * 3 + 2, y * 3);
      end
    end
    if (bad && false_tally != 16'hFFFF) false_tally++;
    v.statement_false = bad;
    v.false_total = false_tally;
    return v;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      wipe_forest();
      false_tally = '0;
      id_limit = ENT_COUNT_RESET;
      expected_verdicts.delete();
    end else begin
      if (start && !busy)
        expected_verdicts.insert(expected_verdicts.size(), judge_statement(in_item));
      if (cfg_we) id_limit = cfg_data;
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_item.statement_false !== want.statement_false)
            report($sformatf("statement_false %b, expected %b",
                             out_item.statement_false, want.statement_false));
          if (out_item.false_total !== want.false_total)
            report($sformatf("false_total %0d, expected %0d",
                             out_item.false_total, want.false_total));
        end
      end
    end
    verdicts_pending = expected_verdicts.size();
  end
endmodule

// ===== sim/relation_consistency_union_find_test.sv =====
module relation_consistency_union_find_test;
  import rcuf_pkg::*;
  import rcuf_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_item;
  logic        cfg_we;
  logic [11:0] cfg_data;
  int          fail_count;
  int          verdicts_pending;
  int          cycles;
  int          beats_sent;
  int          clears_sent;
  int          idle_pct;
  logic [11:0] id_limit;

  relation_consistency_union_find u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  relation_verdict_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .verdicts_pending(verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end
  initial cycles = 0;

  task automatic send_beat(input in_t b);
    start <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (b.mode == MODE_CLEAR) clears_sent++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (verdicts_pending != 0);
  endtask

  task automatic write_limit(input logic [11:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    id_limit = v;
  endtask

  task automatic statement(input logic rel, input int x, input int y);
    in_t b;
    b.mode = MODE_STATEMENT;
    b.relation = rel;
    b.first_id = 12'(x);
    b.second_id = 12'(y);
    send_beat(b);
  endtask

  function automatic int pick_id(input int pool);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(4095);
    if (r < 12) return id_limit + 1 + $urandom_range(3);
    return 1 + $urandom_range(pool - 1);
  endfunction

  task automatic random_beat();
    in_t b;
    int  pool;
    pool = (id_limit == 0) ? 8 : ((id_limit > 48) ? 48 : id_limit);
    if ($urandom_range(199) == 0) begin
      b = in_t'(26'($urandom));
      b.mode = MODE_CLEAR;
    end else begin
      b.mode = MODE_STATEMENT;
      b.relation = 1'($urandom_range(1));
      b.first_id = 12'(pick_id(pool));
      b.second_id = ($urandom_range(29) == 0) ? b.first_id : 12'(pick_id(pool));
    end
    while ($urandom_range(99) < idle_pct) pause(1);
    send_beat(b);
  endtask

  initial begin
    in_t b;
    beats_sent = 0;
    clears_sent = 0;
    id_limit = ENT_COUNT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    b = '0;
    b.mode = MODE_CLEAR;
    b.relation = REL_EATS;
    b.first_id = 12'hFFF;
    b.second_id = 12'hFFF;
    send_beat(b);
    statement(REL_SAME_KIND, 5, 5);
    statement(REL_EATS, 0, 7);
    statement(REL_SAME_KIND, 7, 0);
    statement(REL_SAME_KIND, 4095, 1);
    statement(REL_EATS, 4094, 4095);
    statement(REL_EATS, 1, 2);
    statement(REL_SAME_KIND, 1, 2);
    statement(REL_EATS, 2, 1);
    statement(REL_EATS, 2, 3);
    statement(REL_EATS, 3, 1);
    statement(REL_EATS, 1, 3);
    statement(REL_SAME_KIND, 3, 4094);
    statement(REL_EATS, 2, 4095);
    write_limit(12'd3);
    statement(REL_EATS, 1, 4);
    statement(REL_SAME_KIND, 2, 3);
    statement(REL_EATS, 3, 2);
    write_limit(12'd0);
    statement(REL_SAME_KIND, 1, 2);
    write_limit(12'd4095);
    statement(REL_SAME_KIND, 4094, 1);

    // back-to-back invalid beats
    repeat (20) statement(REL_SAME_KIND, $urandom_range(4095), 0);
    send_beat(b);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 6 : ((ph == 1) ? 83 : 0);
      for (int sub = 0; sub < 2; sub++) begin
        case (ph * 2 + sub)
          0: write_limit(12'd37);
          1: write_limit(12'd4095);
          2: write_limit(12'd1);
          3: write_limit(12'd300);
          4: write_limit(12'd0);
          default: write_limit(12'd60);
        endcase
        for (int i = 0; i < 183; i++) begin
          random_beat();
          if (i == 90) drain();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d beats (%0d clears), limits 0..4095, invalid and merged statements",
             beats_sent, clears_sent);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/rcuf_pkg.sv
sv/rcuf_ram.sv
sv/relation_consistency_union_find.sv
sv/rcuf_chk.sv
sim/rcuf_tb_pkg.sv
sim/relation_verdict_checker.sv
sim/relation_consistency_union_find_test.sv
